/* sv/bct_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bct_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int DIV_W         = 24;
    localparam int CFG_ADDR_W    = 4;
    localparam int REG_IDX_W     = 2;

    localparam logic [REG_IDX_W-1:0] REG_HOME_OFFSET  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PHASE_LEAD   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COUNTS_REV   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_FINE_SCALE   = 2'd3;

    localparam logic [2:0]  HOME_OFFSET_RST = 3'd0;
    localparam logic [2:0]  PHASE_LEAD_RST  = 3'd2;
    localparam logic [9:0]  COUNTS_REV_RST  = 10'd117;
    localparam logic [23:0] FINE_SCALE_RST  = 24'd2188032;

    localparam logic        FUNC_HALL      = 1'b0;
    localparam logic        FUNC_ENC       = 1'b1;
    localparam logic [2:0]  SECTOR_INVALID = 3'd7;
    localparam logic [2:0]  SECTOR_HOME    = 3'd0;
    localparam logic [5:0]  DRIVE_OFF      = 6'h00;
    localparam logic [15:0] POS_MAX        = 16'hFFFF;
    localparam logic [19:0] COARSE_MAX     = 20'd1000000;
    localparam logic [31:0] FINE_MAX       = 32'hFFFFFFFF;

    localparam logic [5:0] DRIVE_LUT [8] = '{6'h12, 6'h18, 6'h09, 6'h21,
                                             6'h24, 6'h06, 6'h00, 6'h00};
    localparam logic [2:0] SECTOR_LUT [8] = '{3'd7, 3'd5, 3'd3, 3'd4,
                                              3'd1, 3'd0, 3'd2, 3'd7};

    typedef struct packed {
        logic        func;
        logic [2:0]  hall_bits;
        logic        enc_a;
        logic        enc_b;
        logic [31:0] time_us;
    } cmd_t;

    typedef struct packed {
        logic [5:0]  drive_pattern;
        logic [2:0]  rotor_sector;
        logic [31:0] speed_fine_q8;
        logic [19:0] speed_coarse_hz;
        logic [15:0] rotor_position_counts;
        logic [31:0] distance_fine_counts;
        logic [31:0] distance_coarse_counts;
    } rsp_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [2:0] drive_state(input logic [2:0] sector,
                                               input logic [2:0] home,
                                               input logic [2:0] lead);
        logic signed [5:0] s;
        logic [4:0]        t;
        s = $signed({3'b000, sector}) - $signed({3'b000, home})
            + $signed({{3{lead[2]}}, lead});
        t = 5'(s + 6'sd12);
        if (t >= 5'd18)
            t = t - 5'd18;
        else if (t >= 5'd12)
            t = t - 5'd12;
        else if (t >= 5'd6)
            t = t - 5'd6;
        return t[2:0];
    endfunction

endpackage

`default_nettype wire

/* sv/bct_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module bct_div #(
    parameter int TIME_BITS = bct_pkg::TIME_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire bct_pkg::div_req_t          req,
    input  wire logic [TIME_BITS-1:0]       divisor,
    output      bct_pkg::div_stat_t         stat,
    output      logic [bct_pkg::DIV_W-1:0]  quotient
);
    import bct_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [TIME_BITS-1:0] dsr_reg, dsr_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [TIME_BITS:0]   trial;
    logic [TIME_BITS:0]   diff;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = req.dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

/* sv/bldc_commutation_and_tracking.sv */
// Six-step hall commutation with encoder distance and speed tracking.
// Requests arrive on cmd (cmd_valid / cmd_ready); each yields exactly one
// response on rsp (rsp_valid / rsp_ready) carrying the drive pattern, the
// decoded sector, both speeds, rotor position and both distances.
// Configuration goes through the APB-style port (home_offset at 0x0,
// phase_lead at 0x4, counts_per_rev at 0x8, fine_speed_scale at 0xC);
// write it only while the block is idle. pready is always high.
// A request that measures speed (hall sector zero or an encoder
// edge with both channels low and a nonzero interval) runs the shared
// restoring divider, one quotient bit per cycle for 24 bits, before it
// enters the done state; other requests go there directly from idle.
// There is a single divider; one request is in work at a time.
// cmd_ready is high whenever no request is in work, also while a response
// still waits in the output register. A stalled receiver holds rsp steady
// and, once a second response is ready, holds the block until rsp is taken.
// Reset clears all tracking state, loads the register defaults and drops
// rsp_valid; the block is ready in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module bldc_commutation_and_tracking #(
    parameter int TIME_BITS = bct_pkg::TIME_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bct_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output      logic [31:0]                    prdata,
    output      logic                           pready,
    input  wire logic                           cmd_valid,
    output      logic                           cmd_ready,
    input  wire bct_pkg::cmd_t                  cmd,
    output      logic                           rsp_valid,
    input  wire logic                           rsp_ready,
    output      bct_pkg::rsp_t                  rsp
);
    import bct_pkg::*;

    localparam int TW = (TIME_BITS < 32) ? TIME_BITS : 32;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [2:0]  home_offset_reg;
    logic [2:0]  phase_lead_reg;
    logic [9:0]  counts_rev_reg;
    logic [23:0] fine_scale_reg;
    logic        cfg_wr;

    logic [1:0]           state_reg, state_next;
    logic [TIME_BITS-1:0] last_enc_reg, last_enc_next;
    logic [TIME_BITS-1:0] last_rev_reg, last_rev_next;
    logic [15:0]          position_reg, position_next;
    logic [31:0]          total_fine_reg, total_fine_next;
    logic [31:0]          total_coarse_reg, total_coarse_next;
    logic                 home_seen_reg, home_seen_next;
    logic [31:0]          speed_fine_reg, speed_fine_next;
    logic [19:0]          speed_coarse_reg, speed_coarse_next;
    logic [5:0]           drive_reg, drive_next;
    logic [2:0]           sector_reg, sector_next;
    logic                 sel_fine_reg, sel_fine_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] dt;
    logic [2:0]           hall_sector;
    div_req_t             div_req;
    div_stat_t            div_stat;
    logic [DIV_W-1:0]     div_quo;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_offset_reg <= HOME_OFFSET_RST;
            phase_lead_reg  <= PHASE_LEAD_RST;
            counts_rev_reg  <= COUNTS_REV_RST;
            fine_scale_reg  <= FINE_SCALE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_HOME_OFFSET: home_offset_reg <= pwdata[2:0];
                REG_PHASE_LEAD:  phase_lead_reg  <= pwdata[2:0];
                REG_COUNTS_REV:  counts_rev_reg  <= pwdata[9:0];
                REG_FINE_SCALE:  fine_scale_reg  <= pwdata[23:0];
                default:         home_offset_reg <= home_offset_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_HOME_OFFSET: prdata = {29'd0, home_offset_reg};
            REG_PHASE_LEAD:  prdata = {29'd0, phase_lead_reg};
            REG_COUNTS_REV:  prdata = {22'd0, counts_rev_reg};
            REG_FINE_SCALE:  prdata = {8'd0, fine_scale_reg};
            default:         prdata = '0;
        endcase
    end

    assign now         = TIME_BITS'(cmd.time_us[TW-1:0]);
    assign dt          = now - ((cmd.func == FUNC_ENC) ? last_enc_reg : last_rev_reg);
    assign hall_sector = SECTOR_LUT[cmd.hall_bits];
    assign cmd_ready   = (state_reg == S_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        last_enc_next     = last_enc_reg;
        last_rev_next     = last_rev_reg;
        position_next     = position_reg;
        total_fine_next   = total_fine_reg;
        total_coarse_next = total_coarse_reg;
        home_seen_next    = home_seen_reg;
        speed_fine_next   = speed_fine_reg;
        speed_coarse_next = speed_coarse_reg;
        drive_next        = drive_reg;
        sector_next       = sector_reg;
        sel_fine_next     = sel_fine_reg;
        div_req.start     = 1'b0;
        div_req.dividend  = DIV_W'(COARSE_MAX);

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next  = S_DONE;
                    sector_next = SECTOR_INVALID;
                    if (cmd.func == FUNC_HALL)
                    begin
                        sector_next = hall_sector;
                        drive_next  = (hall_sector == SECTOR_INVALID) ? DRIVE_OFF :
                            DRIVE_LUT[drive_state(hall_sector, home_offset_reg,
                                                  phase_lead_reg)];
                        if (hall_sector == SECTOR_HOME)
                        begin
                            last_rev_next = now;
                            position_next = '0;
                            if (!home_seen_reg)
                            begin
                                total_coarse_next = total_coarse_reg + 32'(position_reg);
                                home_seen_next    = 1'b1;
                            end
                            else
                            begin
                                total_coarse_next = total_coarse_reg + 32'(counts_rev_reg);
                                total_fine_next   = total_coarse_next;
                            end
                            if (dt == '0)
                                speed_coarse_next = COARSE_MAX;
                            else
                            begin
                                div_req.start = 1'b1;
                                sel_fine_next = 1'b0;
                                state_next    = S_DIV;
                            end
                        end
                    end
                    else if (!cmd.enc_a && !cmd.enc_b)
                    begin
                        if (position_reg != POS_MAX)
                            position_next = position_reg + 16'd1;
                        total_fine_next = total_fine_reg + 32'd1;
                        last_enc_next   = now;
                        if (dt == '0)
                            speed_fine_next = FINE_MAX;
                        else
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = fine_scale_reg;
                            sel_fine_next    = 1'b1;
                            state_next       = S_DIV;
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    if (sel_fine_reg)
                        speed_fine_next = 32'(div_quo);
                    else
                        speed_coarse_next = div_quo[19:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        priority if (state_reg == S_DONE && (!rsp_valid_reg || rsp_ready))
        begin
            rsp_valid_next                  = 1'b1;
            rsp_next.drive_pattern          = drive_reg;
            rsp_next.rotor_sector           = sector_reg;
            rsp_next.speed_fine_q8          = speed_fine_reg;
            rsp_next.speed_coarse_hz        = speed_coarse_reg;
            rsp_next.rotor_position_counts  = position_reg;
            rsp_next.distance_fine_counts   = total_fine_reg;
            rsp_next.distance_coarse_counts = total_coarse_reg;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            last_enc_reg     <= '0;
            last_rev_reg     <= '0;
            position_reg     <= '0;
            total_fine_reg   <= '0;
            total_coarse_reg <= '0;
            home_seen_reg    <= 1'b0;
            speed_fine_reg   <= '0;
            speed_coarse_reg <= '0;
            drive_reg        <= DRIVE_OFF;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            last_enc_reg     <= last_enc_next;
            last_rev_reg     <= last_rev_next;
            position_reg     <= position_next;
            total_fine_reg   <= total_fine_next;
            total_coarse_reg <= total_coarse_next;
            home_seen_reg    <= home_seen_next;
            speed_fine_reg   <= speed_fine_next;
            speed_coarse_reg <= speed_coarse_next;
            drive_reg        <= drive_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sector_reg   <= sector_next;
        sel_fine_reg <= sel_fine_next;
        rsp_reg      <= rsp_next;
    end

    bct_div #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .divisor  (dt),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> (state_reg == S_IDLE && !div_stat.busy))
        else $error("divider started while busy");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> state_reg != S_IDLE)
        else $error("accepted request did not leave idle");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response raised without a finished request");

    a_coarse_bound: assert property (@(posedge clk) disable iff (!rst_n)
        speed_coarse_reg <= COARSE_MAX)
        else $error("coarse speed above its ceiling");

endmodule

`default_nettype wire
